### src/voxel_ray_traversal_assert.svh
// Assertion macros for the voxel ray traversal checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH

// same-cycle implication, disabled in reset
`define VRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define VRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/vrt_pkg.sv
// Shared types and constants of the voxel ray traversal block.
// No dependencies.
`timescale 1ns / 1ps
package vrt_pkg;
	localparam int GRID_BITS = 5;
	localparam int FRAC_BITS = 12;
	localparam int DIR_FRAC  = 14;
	localparam int DIR_W     = 16;
	localparam int COORD_W   = GRID_BITS + FRAC_BITS;
	localparam int MAP_AW    = 3 * GRID_BITS;
	// dividend / quotient width of the setup divisions
	localparam int DVW       = FRAC_BITS + DIR_FRAC + 1;
	// ray parameter width, top bit marks an axis that never steps
	localparam int TW        = DVW + 1;
	// signed cell coordinate, room to walk well off the grid
	localparam int CW        = GRID_BITS + 4;
	localparam int SW        = GRID_BITS + 2;

	localparam logic [COORD_W-1:0] MAXD_RESET = COORD_W'(20480);
	localparam logic [COORD_W-1:0] COORD_MAX  = '1;
	localparam logic [TW-1:0]      T_INF      = TW'(1) << DVW;
	localparam logic [DVW-1:0]     TD_NUM     = DVW'(1) << (FRAC_BITS + DIR_FRAC);
	localparam logic [SW-1:0]      STEP_EXTRA = SW'(3);

	localparam logic CMD_CAST  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_CAST,
		KIND_MISS
	} kind_t;

	typedef struct packed {
		logic                     command;
		logic [COORD_W-1:0]       origin_x;
		logic [COORD_W-1:0]       origin_y;
		logic [COORD_W-1:0]       origin_z;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic signed [DIR_W-1:0]  dir_z;
		logic [GRID_BITS-1:0]     cell_x;
		logic [GRID_BITS-1:0]     cell_y;
		logic [GRID_BITS-1:0]     cell_z;
		logic                     solid;
	} vrt_in_t;

	typedef struct packed {
		logic                     hit;
		logic [GRID_BITS-1:0]     block_x;
		logic [GRID_BITS-1:0]     block_y;
		logic [GRID_BITS-1:0]     block_z;
		logic [1:0]               normal_axis;
		logic                     normal_negative;
		logic [COORD_W-1:0]       distance;
	} vrt_out_t;

	typedef struct packed {
		kind_t   kind;
		vrt_in_t item;
	} q_item_t;
endpackage

### src/voxel_ray_traversal.sv
// Voxel ray traversal: items are carried out one at a time; a write or zero-direction
// item goes from idle straight to the result state, with no setup and no walk.
// A cast item runs two divisions per nonzero direction axis in the shared
// one-bit-a-cycle divider, none per zero axis, then walks cell steps through the single
// map read port, at most floor(3 * max_distance) + 3 steps.
// Reset: clearing all 32768 solid map entries holds cmd_ready low; max_distance 5.0.
`timescale 1ns / 1ps
module voxel_ray_traversal (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [vrt_pkg::COORD_W-1:0] cfg_wr_data,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  vrt_pkg::vrt_in_t            cmd,
	output logic                        res_valid,
	input  logic                        res_ready,
	output vrt_pkg::vrt_out_t           res
);
	import vrt_pkg::*;

	logic    clearing, q_valid, q_pop;
	q_item_t q_item;

	vrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	vrt_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.clearing    (clearing),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);
endmodule

### src/vrt_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clearing,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  vrt_pkg::vrt_in_t  cmd,
	output logic              q_valid,
	input  logic              q_pop,
	output vrt_pkg::q_item_t  q_item
);
	import vrt_pkg::*;

	localparam int QD = 2;

	q_item_t     ent_q [QD];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	kind_t       kind;
	logic        push, pop;

	always_comb begin
		if (cmd.command == CMD_WRITE) begin
			kind = KIND_WRITE;
		end else if (cmd.dir_x == '0 && cmd.dir_y == '0 && cmd.dir_z == '0) begin
			kind = KIND_MISS;
		end else begin
			kind = KIND_CAST;
		end
	end

	assign cmd_ready = (cnt_q != 2'(QD)) && !clearing;
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = cnt_q != '0;
	assign pop       = q_pop && q_valid;
	assign q_item    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{kind: kind, item: cmd};
		end
	end
endmodule

### src/vrt_div.sv
// Restoring divider, one quotient bit per cycle, for the tDelta and tMax setup.
// Depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [vrt_pkg::DVW-1:0]   dividend,
	input  logic [vrt_pkg::DIR_W-1:0] divisor,
	output logic                      done,
	output logic [vrt_pkg::DVW-1:0]   quotient
);
	import vrt_pkg::*;

	localparam int CNT_W = $clog2(DVW + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIR_W-1:0] rem_q;
	logic [DVW-1:0]   quo_q;
	logic [DIR_W:0]   trial;
	logic             take;

	assign trial    = {rem_q, quo_q[DVW-1]};
	assign take     = trial >= {1'b0, divisor};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? DIR_W'(trial - {1'b0, divisor}) : trial[DIR_W-1:0];
			quo_q <= {quo_q[DVW-2:0], take};
		end
	end
endmodule

### src/vrt_walk.sv
// Back end: solid map, per-axis setup through the shared divider, cell walk,
// result register. Depends on vrt_pkg and vrt_div.
`timescale 1ns / 1ps
module vrt_walk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [vrt_pkg::COORD_W-1:0] cfg_wr_data,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  vrt_pkg::q_item_t            q_item,
	output logic                        clearing,
	output logic                        res_valid,
	input  logic                        res_ready,
	output vrt_pkg::vrt_out_t           res
);
	import vrt_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TD,
		ST_TDW,
		ST_TMW,
		ST_STEP,
		ST_CHECK,
		ST_RESP
	} state_t;

	state_t                state_q;
	logic [MAP_AW-1:0]     clr_addr_q;
	logic [COORD_W-1:0]    maxd_q;
	vrt_in_t               item_q;
	logic [1:0]            axis_q;
	logic [TW-1:0]         tdelta_q [3];
	logic [TW-1:0]         tmax_q [3];
	logic signed [CW-1:0]  cell_q [3];
	logic [SW-1:0]         steps_q;
	logic [TW-1:0]         dist_q;
	logic                  hit_q, inb_q, div_start_q;
	logic                  res_valid_q;
	vrt_out_t              res_q;
	logic                  solid_map_q [2**MAP_AW];
	logic                  rd_q;

	logic signed [DIR_W-1:0] dir_a [3];
	logic [COORD_W-1:0]      org_a [3];
	logic signed [DIR_W-1:0] dir;
	logic [DIR_W-1:0]        mag;
	logic [FRAC_BITS:0]      num;
	logic [DVW-1:0]          dividend;
	logic                    div_done;
	logic [DVW-1:0]          quo;
	logic [1:0]              amin;
	logic [TW-1:0]           tsel;
	logic                    stop;
	logic signed [CW-1:0]    ncell [3];
	logic                    ninb;
	logic [COORD_W+1:0]      maxd3;
	logic [SW-1:0]           steps_init;
	logic                    mem_we;
	logic [MAP_AW-1:0]       waddr;
	logic                    res_take;

	assign dir_a[0] = item_q.dir_x;
	assign dir_a[1] = item_q.dir_y;
	assign dir_a[2] = item_q.dir_z;
	assign org_a[0] = item_q.origin_x;
	assign org_a[1] = item_q.origin_y;
	assign org_a[2] = item_q.origin_z;

	// setup operands of the axis being prepared
	assign dir      = dir_a[axis_q];
	assign mag      = dir[DIR_W-1] ? DIR_W'(-dir) : dir;
	assign num      = dir[DIR_W-1] ? {1'b0, org_a[axis_q][FRAC_BITS-1:0]}
		: ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, org_a[axis_q][FRAC_BITS-1:0]};
	assign dividend = (state_q == ST_TDW) ? TD_NUM : {num, {DIR_FRAC{1'b0}}};

	vrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend),
		.divisor  (mag),
		.done     (div_done),
		.quotient (quo)
	);

	// nearest boundary; x wins ties over y and z, y over z
	always_comb begin
		amin = AXIS_X;
		if (tmax_q[1] < tmax_q[0]) amin = AXIS_Y;
		if (tmax_q[2] < tmax_q[amin]) amin = AXIS_Z;
	end
	assign tsel = tmax_q[amin];
	assign stop = (steps_q == '0) || (tsel > TW'(maxd_q));

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ncell[a] = cell_q[a];
			if (2'(a) == amin) begin
				ncell[a] = dir_a[a][DIR_W-1] ? cell_q[a] - 1'b1 : cell_q[a] + 1'b1;
			end
		end
	end
	assign ninb = ncell[0][CW-1:GRID_BITS] == '0 && ncell[1][CW-1:GRID_BITS] == '0
		&& ncell[2][CW-1:GRID_BITS] == '0;

	assign maxd3      = {2'b00, maxd_q} + {1'b0, maxd_q, 1'b0};
	assign steps_init = maxd3[COORD_W+1:FRAC_BITS] + STEP_EXTRA;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign clearing = state_q == ST_CLEAR;
	assign mem_we   = q_pop && q_item.kind == KIND_WRITE;
	assign waddr    = clearing ? clr_addr_q
		: {q_item.item.cell_x, q_item.item.cell_y, q_item.item.cell_z};
	assign res_take = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (clearing || mem_we) begin
			solid_map_q[waddr] <= clearing ? 1'b0 : q_item.item.solid;
		end
		rd_q <= solid_map_q[{ncell[0][GRID_BITS-1:0], ncell[1][GRID_BITS-1:0],
			ncell[2][GRID_BITS-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			maxd_q      <= MAXD_RESET;
			div_start_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			div_start_q <= ((state_q == ST_TD) && (dir != '0))
				|| ((state_q == ST_TDW) && div_done);
			res_valid_q <= ((state_q == ST_RESP) && res_take) || (res_valid_q && !res_ready);
			if (cfg_wr_en) maxd_q <= cfg_wr_data;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item.item;
						hit_q  <= 1'b0;
						axis_q <= AXIS_X;
						steps_q <= steps_init;
						cell_q[0] <= CW'(q_item.item.origin_x[COORD_W-1:FRAC_BITS]);
						cell_q[1] <= CW'(q_item.item.origin_y[COORD_W-1:FRAC_BITS]);
						cell_q[2] <= CW'(q_item.item.origin_z[COORD_W-1:FRAC_BITS]);
						state_q <= (q_item.kind == KIND_CAST) ? ST_TD : ST_RESP;
					end
				end
				ST_TD: begin
					if (dir == '0) begin
						tdelta_q[axis_q] <= T_INF;
						tmax_q[axis_q]   <= T_INF;
						if (axis_q == AXIS_Z) state_q <= ST_STEP;
						else axis_q <= axis_q + 1'b1;
					end else begin
						state_q <= ST_TDW;
					end
				end
				ST_TDW: begin
					if (div_done) begin
						tdelta_q[axis_q] <= TW'(quo);
						state_q          <= ST_TMW;
					end
				end
				ST_TMW: begin
					if (div_done) begin
						tmax_q[axis_q] <= TW'(quo);
						if (axis_q == AXIS_Z) begin
							state_q <= ST_STEP;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_TD;
						end
					end
				end
				ST_STEP: begin
					if (stop) begin
						state_q <= ST_RESP;
					end else begin
						dist_q       <= tsel;
						axis_q       <= amin;
						cell_q[amin] <= ncell[amin];
						tmax_q[amin] <= tsel + tdelta_q[amin];
						steps_q      <= steps_q - 1'b1;
						inb_q        <= ninb;
						state_q      <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (rd_q && inb_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_RESP: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && res_take) begin
			if (hit_q) begin
				res_q.hit             <= 1'b1;
				res_q.block_x         <= cell_q[0][GRID_BITS-1:0];
				res_q.block_y         <= cell_q[1][GRID_BITS-1:0];
				res_q.block_z         <= cell_q[2][GRID_BITS-1:0];
				res_q.normal_axis     <= axis_q;
				res_q.normal_negative <= !dir_a[axis_q][DIR_W-1];
				res_q.distance        <= (dist_q > TW'(COORD_MAX)) ? COORD_MAX
					: dist_q[COORD_W-1:0];
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

### src/vrt_checker.sv
// Port-level checks of voxel_ray_traversal, bound to the top level.
// Depends on vrt_pkg and voxel_ray_traversal_assert.svh.
`timescale 1ns / 1ps
`include "voxel_ray_traversal_assert.svh"
module vrt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_wr_en,
	input logic [vrt_pkg::COORD_W-1:0] cfg_wr_data,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input vrt_pkg::vrt_in_t            cmd,
	input logic                        res_valid,
	input logic                        res_ready,
	input vrt_pkg::vrt_out_t           res
);
	import vrt_pkg::*;

	`VRT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`VRT_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res), "result changed while stalled")
	`VRT_ASSERT_NOW(a_miss_zero, res_valid && !res.hit, res.block_x == '0 && res.block_y == '0 && res.block_z == '0 && res.normal_axis == AXIS_X && !res.normal_negative && res.distance == '0, "miss or write item with nonzero fields")
	`VRT_ASSERT_NOW(a_axis_code, res_valid && res.hit, res.normal_axis == AXIS_X || res.normal_axis == AXIS_Y || res.normal_axis == AXIS_Z, "bad normal axis")
endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);
